[rtl/prtrs_pkg.sv]
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared widths, codes, the task table entry layout and the deadline test.
// ----------------------------------------------------------------------------
package prtrs_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int PRIO_W     = 8;
  localparam int QID_W      = 8;
  localparam int TICK_W     = 32;

  typedef logic [2:0] tstate_t;
  localparam tstate_t TS_FREE    = 3'd0;
  localparam tstate_t TS_READY   = 3'd1;
  localparam tstate_t TS_RUNNING = 3'd2;
  localparam tstate_t TS_BLOCKED = 3'd3;
  localparam tstate_t TS_DEAD    = 3'd4;

  typedef logic [3:0] op_t;
  localparam op_t OP_TICK   = 4'd0;
  localparam op_t OP_CREATE = 4'd1;
  localparam op_t OP_FREE   = 4'd2;
  localparam op_t OP_START  = 4'd3;
  localparam op_t OP_YIELD  = 4'd4;
  localparam op_t OP_DELAY  = 4'd5;
  localparam op_t OP_PARK   = 4'd6;
  localparam op_t OP_WAKE   = 4'd7;
  localparam op_t OP_FINISH = 4'd8;

  typedef logic [1:0] status_t;
  localparam status_t STS_OK      = 2'd0;
  localparam status_t STS_NOSLOT  = 2'd1;
  localparam status_t STS_TIMEOUT = 2'd2;
  localparam status_t STS_IGNORED = 2'd3;

  typedef struct packed {
    tstate_t            st;
    logic [PRIO_W-1:0]  prio;
    logic [TICK_W-1:0]  wake;
    logic               dv;
    logic [QID_W-1:0]   qid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // wrap-safe: deadline reached when (now - deadline) is non-negative
  function automatic logic tick_reached(input logic [TICK_W-1:0] now,
                                        input logic [TICK_W-1:0] deadline);
    logic [TICK_W-1:0] diff;
    diff = now - deadline;
    return ~diff[TICK_W-1];
  endfunction

endpackage

[rtl/prtrs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module prtrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/priority_round_robin_task_scheduler.sv]
// ----------------------------------------------------------------------------
// Priority round-robin task scheduler
// Task table in RAM, event sequencer and scheduling pass.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid/in_stall) carrying an op and
// its operands; each request yields exactly one result on the output channel
// (out_valid/out_stall): status, slot_index, slot_valid and tick_now.
// The task table sits in a one-read one-write RAM; each slot has a valid bit
// in flops so slots never written read as free with zeroed fields.
// Tick without a pass, free and ignored requests go straight to the result;
// create and wake scan the table, one slot per cycle; a scheduling pass
// reads all 16 slots (waking expired waiters as it goes), then writes back
// the chosen task, with a modify of the running task first. The table scan
// sets the rate: one request at a time, the next one taken the cycle after
// the result is loaded. Reset empties the table, clears the tick counter and
// the current task; no clearing pass is needed. A new request is taken while
// the previous result waits in the output register; a request that completes
// while the receiver stalls holds until that result has gone.
module priority_round_robin_task_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   op,
  input  logic [prtrs_pkg::PRIO_W-1:0] priority_req,
  input  logic [3:0]                   slot,
  input  logic [31:0]                  ticks,
  input  logic [prtrs_pkg::QID_W-1:0]  queue_id,
  input  logic                         forever_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [3:0]                   slot_index,
  output logic                         slot_valid,
  output logic [31:0]                  tick_now
);

  localparam int SW = prtrs_pkg::SLOT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_CREATE = 3'd5;
  localparam logic [2:0] S_WAKE   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] fsm, fsm_next;

  prtrs_pkg::op_t                op_q, op_q_next;
  logic [prtrs_pkg::PRIO_W-1:0]  prio_q, prio_q_next;
  logic [SW-1:0]                 slot_q, slot_q_next;
  logic [31:0]                   ticks_q, ticks_q_next;
  logic [prtrs_pkg::QID_W-1:0]   qid_q, qid_q_next;
  logic                          forever_q, forever_q_next;

  logic [31:0]   tick_count, tick_count_next;
  logic          started, started_next;
  logic [SW-1:0] cur_slot, cur_slot_next;
  logic          cur_valid, cur_valid_next;
  logic          run_flag, run_flag_next;
  logic [prtrs_pkg::TASK_SLOTS-1:0] vld;

  logic [SW:0]   scan_cnt, scan_cnt_next;
  logic          rd_pend, rd_pend_next;
  logic [SW-1:0] rd_addr_q;
  logic          rd_vld_q;

  logic                found, found_next;
  logic [SW-1:0]       best_slot, best_slot_next;
  logic [SW-1:0]       best_dist, best_dist_next;
  prtrs_pkg::entry_t   best_ent, best_ent_next;

  prtrs_pkg::status_t  res_status, res_status_next;
  logic [SW-1:0]       res_slot, res_slot_next;
  logic                res_svalid, res_svalid_next;
  logic                out_valid_next;
  logic                out_load;

  logic                         ram_we;
  logic [SW-1:0]                ram_waddr;
  prtrs_pkg::entry_t            ram_wdata;
  logic [SW-1:0]                ram_raddr;
  logic [prtrs_pkg::ENTRY_W-1:0] ram_rdata;

  prtrs_pkg::entry_t ent, e_mod, e_scan;
  logic [SW-1:0]     scan_start, rr_off;
  logic              last;
  logic [31:0]       dly, park_dl;

  prtrs_ram #(
    .WIDTH (prtrs_pkg::ENTRY_W),
    .DEPTH (prtrs_pkg::TASK_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (fsm != S_IDLE);
  assign ent      = rd_vld_q ? prtrs_pkg::entry_t'(ram_rdata) : '0;
  assign last     = (rd_addr_q == SW'(prtrs_pkg::TASK_SLOTS - 1));
  assign scan_start = cur_valid ? cur_slot + SW'(1) : '0;
  assign rr_off   = rd_addr_q - scan_start;
  assign dly      = tick_count + ((ticks_q == 32'd0) ? 32'd1 : ticks_q);
  assign park_dl  = tick_count + ticks_q;

  always_comb begin
    fsm_next        = fsm;
    op_q_next       = op_q;
    prio_q_next     = prio_q;
    slot_q_next     = slot_q;
    ticks_q_next    = ticks_q;
    qid_q_next      = qid_q;
    forever_q_next  = forever_q;
    tick_count_next = tick_count;
    started_next    = started;
    cur_slot_next   = cur_slot;
    cur_valid_next  = cur_valid;
    run_flag_next   = run_flag;
    scan_cnt_next   = scan_cnt;
    found_next      = found;
    best_slot_next  = best_slot;
    best_dist_next  = best_dist;
    best_ent_next   = best_ent;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_svalid_next = res_svalid;
    out_load        = 1'b0;
    out_valid_next  = out_valid & out_stall;
    ram_we          = 1'b0;
    ram_waddr       = rd_addr_q;
    ram_wdata       = ent;
    ram_raddr       = scan_cnt[SW-1:0];
    rd_pend_next    = 1'b0;
    e_mod           = ent;
    e_scan          = ent;

    // slot reads for the table scans, one per cycle
    if ((fsm == S_SCAN || fsm == S_CREATE || fsm == S_WAKE) && !scan_cnt[SW]) begin
      rd_pend_next  = 1'b1;
      scan_cnt_next = scan_cnt + (SW+1)'(1);
    end

    unique case (fsm)
      S_IDLE: begin
        if (in_valid) begin
          op_q_next      = op;
          prio_q_next    = priority_req;
          slot_q_next    = slot;
          ticks_q_next   = ticks;
          qid_q_next     = queue_id;
          forever_q_next = forever_req;
          fsm_next       = S_DEC;
        end
      end
      S_DEC: begin
        res_status_next = prtrs_pkg::STS_OK;
        res_slot_next   = '0;
        res_svalid_next = 1'b0;
        scan_cnt_next   = '0;
        found_next      = 1'b0;
        ram_raddr       = cur_slot;
        fsm_next        = S_DONE;
        unique case (op_q)
          prtrs_pkg::OP_TICK: begin
            tick_count_next = tick_count + 32'd1;
            if (started && !run_flag) fsm_next = S_SCAN;
          end
          prtrs_pkg::OP_CREATE: fsm_next = S_CREATE;
          prtrs_pkg::OP_FREE: begin
            ram_we    = 1'b1;
            ram_waddr = slot_q;
            ram_wdata = '0;
            if (cur_valid && slot_q == cur_slot) run_flag_next = 1'b0;
          end
          prtrs_pkg::OP_START: begin
            if (started) begin
              res_status_next = prtrs_pkg::STS_IGNORED;
            end else begin
              started_next = 1'b1;
              fsm_next     = S_SCAN;
            end
          end
          prtrs_pkg::OP_YIELD, prtrs_pkg::OP_DELAY, prtrs_pkg::OP_FINISH: begin
            if (!started || !run_flag) res_status_next = prtrs_pkg::STS_IGNORED;
            else fsm_next = S_MOD;
          end
          prtrs_pkg::OP_PARK: begin
            if (!started || !run_flag || qid_q == '0) begin
              res_status_next = prtrs_pkg::STS_IGNORED;
            end else if (!forever_q && prtrs_pkg::tick_reached(tick_count, park_dl)) begin
              res_status_next = prtrs_pkg::STS_TIMEOUT;
            end else begin
              fsm_next = S_MOD;
            end
          end
          prtrs_pkg::OP_WAKE: begin
            if (qid_q == '0) res_status_next = prtrs_pkg::STS_IGNORED;
            else fsm_next = S_WAKE;
          end
          default: res_status_next = prtrs_pkg::STS_IGNORED;
        endcase
      end
      S_MOD: begin
        unique case (op_q)
          prtrs_pkg::OP_YIELD: e_mod.st = prtrs_pkg::TS_READY;
          prtrs_pkg::OP_DELAY: begin
            e_mod.wake = dly;
            e_mod.dv   = 1'b1;
            e_mod.st   = prtrs_pkg::TS_BLOCKED;
          end
          prtrs_pkg::OP_PARK: begin
            e_mod.qid  = qid_q;
            e_mod.wake = forever_q ? 32'd0 : park_dl;
            e_mod.dv   = ~forever_q;
            e_mod.st   = prtrs_pkg::TS_BLOCKED;
          end
          default: e_mod.st = prtrs_pkg::TS_DEAD;
        endcase
        ram_we        = 1'b1;
        ram_waddr     = cur_slot;
        ram_wdata     = e_mod;
        run_flag_next = 1'b0;
        fsm_next      = S_SCAN;
      end
      S_SCAN: begin
        if (rd_pend) begin
          if (ent.st == prtrs_pkg::TS_BLOCKED && ent.dv &&
              prtrs_pkg::tick_reached(tick_count, ent.wake)) begin
            e_scan.st  = prtrs_pkg::TS_READY;
            e_scan.qid = '0;
            e_scan.dv  = 1'b0;
            ram_we     = 1'b1;
            ram_wdata  = e_scan;
          end
          if (e_scan.st == prtrs_pkg::TS_READY &&
              (!found || e_scan.prio > best_ent.prio ||
               (e_scan.prio == best_ent.prio && rr_off < best_dist))) begin
            found_next     = 1'b1;
            best_slot_next = rd_addr_q;
            best_dist_next = rr_off;
            best_ent_next  = e_scan;
          end
          if (last) fsm_next = S_PICK;
        end
      end
      S_PICK: begin
        if (found) begin
          ram_we          = 1'b1;
          ram_waddr       = best_slot;
          ram_wdata       = best_ent;
          ram_wdata.st    = prtrs_pkg::TS_RUNNING;
          cur_slot_next   = best_slot;
          cur_valid_next  = 1'b1;
          run_flag_next   = 1'b1;
          res_slot_next   = best_slot;
          res_svalid_next = 1'b1;
        end
        fsm_next = S_DONE;
      end
      S_CREATE: begin
        if (rd_pend) begin
          if (ent.st == prtrs_pkg::TS_FREE) begin
            ram_we          = 1'b1;
            ram_wdata       = '0;
            ram_wdata.st    = prtrs_pkg::TS_READY;
            ram_wdata.prio  = prio_q;
            res_slot_next   = rd_addr_q;
            res_svalid_next = 1'b1;
            fsm_next        = S_DONE;
          end else if (last) begin
            res_status_next = prtrs_pkg::STS_NOSLOT;
            fsm_next        = S_DONE;
          end
        end
      end
      S_WAKE: begin
        if (rd_pend) begin
          if (ent.st == prtrs_pkg::TS_BLOCKED && ent.qid == qid_q) begin
            e_scan.st       = prtrs_pkg::TS_READY;
            e_scan.qid      = '0;
            e_scan.dv       = 1'b0;
            ram_we          = 1'b1;
            ram_wdata       = e_scan;
            res_slot_next   = rd_addr_q;
            res_svalid_next = 1'b1;
            fsm_next        = S_DONE;
          end else if (last) begin
            fsm_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          fsm_next       = S_IDLE;
        end
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= S_IDLE;
      tick_count <= '0;
      started    <= 1'b0;
      cur_slot   <= '0;
      cur_valid  <= 1'b0;
      run_flag   <= 1'b0;
      vld        <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      fsm        <= fsm_next;
      tick_count <= tick_count_next;
      started    <= started_next;
      cur_slot   <= cur_slot_next;
      cur_valid  <= cur_valid_next;
      run_flag   <= run_flag_next;
      rd_pend    <= rd_pend_next;
      out_valid  <= out_valid_next;
      if (ram_we) vld[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    prio_q     <= prio_q_next;
    slot_q     <= slot_q_next;
    ticks_q    <= ticks_q_next;
    qid_q      <= qid_q_next;
    forever_q  <= forever_q_next;
    scan_cnt   <= scan_cnt_next;
    rd_addr_q  <= ram_raddr;
    rd_vld_q   <= vld[ram_raddr];
    found      <= found_next;
    best_slot  <= best_slot_next;
    best_dist  <= best_dist_next;
    best_ent   <= best_ent_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_svalid <= res_svalid_next;
    if (out_load) begin
      status     <= res_status;
      slot_index <= res_slot;
      slot_valid <= res_svalid;
      tick_now   <= tick_count;
    end
  end

endmodule

[rtl/prtrs_checker.sv]
// ----------------------------------------------------------------------------
// Task scheduler port checker
// Checks on what the scheduler's ports show over time.
// ----------------------------------------------------------------------------
module prtrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [3:0]  slot_index,
  input logic        slot_valid,
  input logic [31:0] tick_now
);

  // one request at a time: busy right after an accept
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a request is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(tick_now) && $stable(status)))
    else $error("stalled result changed");

  a_slot_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && slot_valid) |-> (status == prtrs_pkg::STS_OK))
    else $error("slot reported with non-ok status");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !slot_valid) |-> (slot_index == 4'd0))
    else $error("slot index set without a slot");

endmodule

bind priority_round_robin_task_scheduler prtrs_checker u_prtrs_checker (.*);
